FILE: sv/prr_pkg.sv
// ----------------------------------------------------------------------------
// prr_pkg: shared types and constants for the point-at ray residual block
// Register map, fixed field widths and the scaling of the unit direction.
// ----------------------------------------------------------------------------
package prr_pkg;

    // Register indexes of the configuration port (word address = 4 * index)
    typedef enum logic [2:0] {
        REG_TARGET_X   = 3'd0,
        REG_TARGET_Y   = 3'd1,
        REG_TARGET_Z   = 3'd2,
        REG_RAY_TOL    = 3'd3,
        REG_LIMIT_TOL  = 3'd4,
        REG_MIN_DIST   = 3'd5,
        REG_MAX_DIST   = 3'd6,
        REG_LIMIT_MODE = 3'd7
    } cfg_reg_t;

    localparam int COORD_W  = 32;           // input and target coordinates
    localparam int POS_W    = 31;           // unsigned register and output widths
    localparam int LANES    = 3;            // x, y, z
    localparam int UNIT_BITS = 30;          // unit vector is Q2.30
    localparam int Q_W      = UNIT_BITS + 1;          // unit component magnitude
    localparam int DEN_W    = COORD_W;                // direction norm
    localparam int NUM_W    = COORD_W + UNIT_BITS;    // dividend of the unit divide

    localparam logic [POS_W-1:0] RAY_TOL_RESET   = 31'd655;
    localparam logic [POS_W-1:0] LIMIT_TOL_RESET = 31'd66;

endpackage

FILE: sv/prr_isqrt.sv
// ----------------------------------------------------------------------------
// prr_isqrt: pipelined floor square root
// One result bit per stage, restoring digit-by-digit method; a side word
// travels with each radicand so that callers need no separate delay line.
// ----------------------------------------------------------------------------
module prr_isqrt #(
    parameter int IN_W   = 64,
    parameter int PASS_W = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                ce,
    input  logic                in_valid,
    input  logic [IN_W-1:0]     radicand,
    input  logic [PASS_W-1:0]   pass_in,
    output logic                out_valid,
    output logic [IN_W/2-1:0]   root,
    output logic [PASS_W-1:0]   pass_out
);
    localparam int R  = IN_W / 2;
    localparam int RW = R + 2;

    logic              valid_reg [R];
    logic [IN_W-1:0]   x_reg     [R];
    logic [RW-1:0]     rem_reg   [R];
    logic [R-1:0]      root_reg  [R];
    logic [PASS_W-1:0] pass_reg  [R];

    for (genvar k = 0; k < R; k++) begin : g_step
        logic              v_in;
        logic [IN_W-1:0]   x_in;
        logic [RW-1:0]     rem_in;
        logic [R-1:0]      root_in;
        logic [PASS_W-1:0] p_in;
        logic [RW+1:0]     rem_full;
        logic [RW+1:0]     trial;
        logic              fit;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign x_in    = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
            assign p_in    = pass_in;
        end else begin : g_rest
            assign v_in    = valid_reg[k-1];
            assign x_in    = x_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign p_in    = pass_reg[k-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign rem_full = {rem_in, x_in[IN_W-1 -: 2]};
        assign trial    = {2'b00, root_in, 2'b01};
        assign fit      = (rem_full >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (ce) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                x_reg[k]    <= x_in << 2;
                rem_reg[k]  <= fit ? RW'(rem_full - trial) : RW'(rem_full);
                root_reg[k] <= {root_in[R-2:0], fit};
                pass_reg[k] <= p_in;
            end
        end
    end

    assign out_valid = valid_reg[R-1];
    assign root      = root_reg[R-1];
    assign pass_out  = pass_reg[R-1];

endmodule

FILE: sv/prr_udiv.sv
// ----------------------------------------------------------------------------
// prr_udiv: pipelined three-lane divide by a shared norm
// Restoring division, one quotient bit per stage in each lane. The quotient
// is known to fit in Q_W bits, so the upper dividend bits seed the remainder.
// ----------------------------------------------------------------------------
module prr_udiv #(
    parameter int PASS_W = 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          ce,
    input  logic                          in_valid,
    input  logic [prr_pkg::NUM_W-1:0]     num [prr_pkg::LANES],
    input  logic [prr_pkg::DEN_W-1:0]     den,
    input  logic [PASS_W-1:0]             pass_in,
    output logic                          out_valid,
    output logic [prr_pkg::Q_W-1:0]       quot [prr_pkg::LANES],
    output logic [PASS_W-1:0]             pass_out
);
    import prr_pkg::*;

    localparam int STEPS = Q_W;

    logic              valid_reg [STEPS];
    logic [DEN_W-1:0]  den_reg   [STEPS];
    logic [PASS_W-1:0] pass_reg  [STEPS];
    logic [DEN_W-1:0]  rem_reg   [STEPS][LANES];
    logic [Q_W-1:0]    bits_reg  [STEPS][LANES];
    logic [Q_W-1:0]    q_reg     [STEPS][LANES];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic              v_in;
        logic [DEN_W-1:0]  d_in;
        logic [PASS_W-1:0] p_in;

        if (k == 0) begin : g_first
            assign v_in = in_valid;
            assign d_in = den;
            assign p_in = pass_in;
        end else begin : g_rest
            assign v_in = valid_reg[k-1];
            assign d_in = den_reg[k-1];
            assign p_in = pass_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (ce) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                den_reg[k]  <= d_in;
                pass_reg[k] <= p_in;
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [DEN_W-1:0] rem_in;
            logic [Q_W-1:0]   bits_in;
            logic [Q_W-1:0]   q_in;
            logic [DEN_W:0]   rem_full;
            logic             fit;

            if (k == 0) begin : g_first
                assign rem_in  = DEN_W'(num[l][NUM_W-1:Q_W]);
                assign bits_in = num[l][Q_W-1:0];
                assign q_in    = '0;
            end else begin : g_rest
                assign rem_in  = rem_reg[k-1][l];
                assign bits_in = bits_reg[k-1][l];
                assign q_in    = q_reg[k-1][l];
            end

            assign rem_full = {rem_in, bits_in[Q_W-1]};
            assign fit      = (rem_full >= {1'b0, d_in});

            always_ff @(posedge aclk) begin
                if (ce) begin
                    rem_reg[k][l]  <= fit ? DEN_W'(rem_full - {1'b0, d_in})
                                          : DEN_W'(rem_full);
                    bits_reg[k][l] <= bits_in << 1;
                    q_reg[k][l]    <= {q_in[Q_W-2:0], fit};
                end
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign pass_out  = pass_reg[STEPS-1];
    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign quot[l] = q_reg[STEPS-1][l];
    end

endmodule

FILE: sv/point_at_ray_residual_top.sv
// ----------------------------------------------------------------------------
// point_at_ray_residual_top: distance from a target point to a ray
// Normalises each ray direction, projects the target onto the ray and gives
// the penalised ray distance, the distance limit residual and status flags.
// ----------------------------------------------------------------------------
// One word enters per clock and one result word leaves per clock while the
// output is not stalled. Between input handshake and result valid lies the
// chain of bit-serial stages: a 32-stage square root for the direction norm,
// a 31-stage three-lane divide for the unit vector and two parallel 35-stage
// square roots for |target-origin| and the perpendicular length, plus
// fourteen stages of subtract, square, sum and multiply around them. The
// whole pipeline advances together: it moves whenever the output register
// is empty or being taken, so a stall at the output holds every word in
// place and nothing is dropped or repeated. Write configuration only while
// no word is in flight; the target is sampled at entry and the limits and
// tolerances at the last two stages. Values are signed Q16.16; results
// saturate to their field ranges, and a zero direction gives t = 0.
// ----------------------------------------------------------------------------
module point_at_ray_residual_top (
    input  logic         aclk,
    input  logic         aresetn,
    // input words
    input  logic         s_tvalid,
    output logic         s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each, low first)
    input  logic [191:0] s_tdata,
    // result words
    output logic         m_tvalid,
    input  logic         m_tready,
    // ray_distance [30:0], limit_residual [62:31], zero pad [63]
    output logic [63:0]  m_tdata,
    // limit_active [0], satisfied [1], direction_zero [2]
    output logic [2:0]   m_tuser,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import prr_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] tgt_reg [LANES];
    logic [POS_W-1:0]          ray_tol_reg;
    logic [POS_W-1:0]          lim_tol_reg;
    logic [POS_W-1:0]          min_dist_reg;
    logic [POS_W-1:0]          max_dist_reg;
    logic [1:0]                lim_mode_reg;
    cfg_reg_t                  cfg_idx;
    logic                      cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = cfg_reg_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LANES; i++) tgt_reg[i] <= '0;
            ray_tol_reg  <= RAY_TOL_RESET;
            lim_tol_reg  <= LIMIT_TOL_RESET;
            min_dist_reg <= '0;
            max_dist_reg <= '0;
            lim_mode_reg <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_TARGET_X:   tgt_reg[0]   <= pwdata;
                REG_TARGET_Y:   tgt_reg[1]   <= pwdata;
                REG_TARGET_Z:   tgt_reg[2]   <= pwdata;
                REG_RAY_TOL:    ray_tol_reg  <= pwdata[POS_W-1:0];
                REG_LIMIT_TOL:  lim_tol_reg  <= pwdata[POS_W-1:0];
                REG_MIN_DIST:   min_dist_reg <= pwdata[POS_W-1:0];
                REG_MAX_DIST:   max_dist_reg <= pwdata[POS_W-1:0];
                REG_LIMIT_MODE: lim_mode_reg <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_TARGET_X:   prdata = tgt_reg[0];
            REG_TARGET_Y:   prdata = tgt_reg[1];
            REG_TARGET_Z:   prdata = tgt_reg[2];
            REG_RAY_TOL:    prdata = {1'b0, ray_tol_reg};
            REG_LIMIT_TOL:  prdata = {1'b0, lim_tol_reg};
            REG_MIN_DIST:   prdata = {1'b0, min_dist_reg};
            REG_MAX_DIST:   prdata = {1'b0, max_dist_reg};
            REG_LIMIT_MODE: prdata = {30'd0, lim_mode_reg};
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Global advance: move every stage when the output slot is being taken or is free
    // ------------------------------------------------------------------
    logic ce;
    logic out_valid_reg;

    assign ce       = !out_valid_reg || m_tready;
    assign s_tready = ce;

    // ------------------------------------------------------------------
    // Stage 1: v = target - origin, direction magnitudes and signs
    // ------------------------------------------------------------------
    logic                    st1_valid_reg;
    logic signed [32:0]      st1_v_reg    [LANES];
    logic [31:0]             st1_md_reg   [LANES];
    logic [LANES-1:0]        st1_dneg_reg;
    logic                    st1_zero_reg;

    logic signed [32:0]      st1_v_next   [LANES];
    logic [31:0]             st1_md_next  [LANES];
    logic [LANES-1:0]        st1_dneg_next;

    always_comb begin
        logic signed [31:0] org;
        logic signed [31:0] dir;
        for (int i = 0; i < LANES; i++) begin
            org = s_tdata[32*i +: 32];
            dir = s_tdata[96 + 32*i +: 32];
            st1_v_next[i]    = {tgt_reg[i][31], tgt_reg[i]} - {org[31], org};
            st1_dneg_next[i] = dir[31];
            st1_md_next[i]   = dir[31] ? 32'(-dir) : 32'(dir);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: shift the direction so its largest magnitude has bit 30 or 31
    // ------------------------------------------------------------------
    logic                    st2_valid_reg;
    logic signed [32:0]      st2_v_reg    [LANES];
    logic [31:0]             st2_m_reg    [LANES];
    logic [LANES-1:0]        st2_dneg_reg;
    logic                    st2_zero_reg;

    logic [31:0]             st2_mx;
    logic [4:0]              st2_sh;

    always_comb begin
        st2_mx = st1_md_reg[0];
        if (st1_md_reg[1] > st2_mx) st2_mx = st1_md_reg[1];
        if (st1_md_reg[2] > st2_mx) st2_mx = st1_md_reg[2];
        // highest set bit wins; full scale needs no shift
        st2_sh = '0;
        for (int b = 0; b < 31; b++) begin
            if (st2_mx[b]) st2_sh = 5'(30 - b);
        end
        if (st2_mx[31]) st2_sh = '0;
    end

    // ------------------------------------------------------------------
    // Stage 3: squares of the shifted direction
    // ------------------------------------------------------------------
    logic                    st3_valid_reg;
    logic signed [32:0]      st3_v_reg    [LANES];
    logic [31:0]             st3_m_reg    [LANES];
    logic [63:0]             st3_sq_reg   [LANES];
    logic [LANES-1:0]        st3_dneg_reg;
    logic                    st3_zero_reg;

    // ------------------------------------------------------------------
    // Stage 4: sum of squares into the norm square root
    // ------------------------------------------------------------------
    logic                    st4_valid_reg;
    logic signed [32:0]      st4_v_reg    [LANES];
    logic [31:0]             st4_m_reg    [LANES];
    logic [63:0]             st4_sum_reg;
    logic [LANES-1:0]        st4_dneg_reg;
    logic                    st4_zero_reg;

    localparam int N_PASS_W = 3*33 + 3*32 + LANES + 1;

    logic [N_PASS_W-1:0]     sqn_pass_in;
    logic [N_PASS_W-1:0]     sqn_pass_out;
    logic                    sqn_valid;
    logic [31:0]             sqn_root;

    assign sqn_pass_in = {st4_v_reg[2], st4_v_reg[1], st4_v_reg[0],
                          st4_m_reg[2], st4_m_reg[1], st4_m_reg[0],
                          st4_dneg_reg, st4_zero_reg};

    prr_isqrt #(
        .IN_W   (64),
        .PASS_W (N_PASS_W)
    ) u_sqrt_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (st4_valid_reg),
        .radicand  (st4_sum_reg),
        .pass_in   (sqn_pass_in),
        .out_valid (sqn_valid),
        .root      (sqn_root),
        .pass_out  (sqn_pass_out)
    );

    // ------------------------------------------------------------------
    // Stage 5: dividends m*2^30 + n/2 for rounding to nearest
    // ------------------------------------------------------------------
    logic                    st5_valid_reg;
    logic [NUM_W-1:0]        st5_num_reg  [LANES];
    logic [DEN_W-1:0]        st5_den_reg;
    logic signed [32:0]      st5_v_reg    [LANES];
    logic [LANES-1:0]        st5_dneg_reg;
    logic                    st5_zero_reg;

    logic [31:0]             sqn_m        [LANES];
    logic signed [32:0]      sqn_v        [LANES];
    logic [LANES-1:0]        sqn_dneg;
    logic                    sqn_zero;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            sqn_v[i] = sqn_pass_out[LANES + 1 + 96 + 33*i +: 33];
            sqn_m[i] = sqn_pass_out[LANES + 1 + 32*i +: 32];
        end
        sqn_dneg = sqn_pass_out[LANES:1];
        sqn_zero = sqn_pass_out[0];
    end

    localparam int D_PASS_W = 3*33 + LANES + 1;

    logic [D_PASS_W-1:0]     div_pass_in;
    logic [D_PASS_W-1:0]     div_pass_out;
    logic                    div_valid;
    logic [Q_W-1:0]          div_q        [LANES];

    assign div_pass_in = {st5_v_reg[2], st5_v_reg[1], st5_v_reg[0],
                          st5_dneg_reg, st5_zero_reg};

    prr_udiv #(
        .PASS_W (D_PASS_W)
    ) u_unit_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (st5_valid_reg),
        .num       (st5_num_reg),
        .den       (st5_den_reg),
        .pass_in   (div_pass_in),
        .out_valid (div_valid),
        .quot      (div_q),
        .pass_out  (div_pass_out)
    );

    logic signed [32:0]      div_v        [LANES];
    logic [LANES-1:0]        div_dneg;
    logic                    div_zero;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            div_v[i] = div_pass_out[LANES + 1 + 33*i +: 33];
        end
        div_dneg = div_pass_out[LANES:1];
        div_zero = div_pass_out[0];
    end

    // ------------------------------------------------------------------
    // Stage 6: |v_i| * |u_i|; zero direction forces a zero unit vector
    // ------------------------------------------------------------------
    logic                    st6_valid_reg;
    logic [62:0]             st6_prod_reg [LANES];
    logic [LANES-1:0]        st6_neg_reg;
    logic [Q_W-1:0]          st6_q_reg    [LANES];
    logic signed [32:0]      st6_v_reg    [LANES];
    logic [LANES-1:0]        st6_dneg_reg;
    logic                    st6_zero_reg;

    logic [Q_W-1:0]          st6_q_next   [LANES];
    logic [31:0]             st6_vmag     [LANES];

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            st6_q_next[i] = div_zero ? '0 : div_q[i];
            st6_vmag[i]   = div_v[i][32] ? 32'(-div_v[i]) : 32'(div_v[i]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: round each product by 2^30, ties away from zero, sign back
    // ------------------------------------------------------------------
    logic                    st7_valid_reg;
    logic signed [34:0]      st7_tv_reg   [LANES];
    logic [Q_W-1:0]          st7_q_reg    [LANES];
    logic signed [32:0]      st7_v_reg    [LANES];
    logic [LANES-1:0]        st7_dneg_reg;
    logic                    st7_zero_reg;

    logic signed [34:0]      st7_tv_next  [LANES];

    always_comb begin
        logic [63:0] rsum;
        logic [33:0] r;
        for (int i = 0; i < LANES; i++) begin
            rsum = {1'b0, st6_prod_reg[i]} + (64'd1 << (UNIT_BITS - 1));
            r    = rsum[63:UNIT_BITS];
            st7_tv_next[i] = st6_neg_reg[i] ? -$signed({1'b0, r}) : $signed({1'b0, r});
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: t = sum of the three rounded products
    // ------------------------------------------------------------------
    logic                    st8_valid_reg;
    logic signed [34:0]      st8_t_reg;
    logic [Q_W-1:0]          st8_q_reg    [LANES];
    logic signed [32:0]      st8_v_reg    [LANES];
    logic [LANES-1:0]        st8_dneg_reg;
    logic                    st8_zero_reg;

    logic signed [36:0]      st8_t_wide;

    assign st8_t_wide = 37'(st7_tv_reg[0]) + 37'(st7_tv_reg[1]) + 37'(st7_tv_reg[2]);

    // ------------------------------------------------------------------
    // Stage 9: |t| * |u_i|
    // ------------------------------------------------------------------
    logic                    st9_valid_reg;
    logic [64:0]             st9_prod_reg [LANES];
    logic [LANES-1:0]        st9_neg_reg;
    logic signed [32:0]      st9_v_reg    [LANES];
    logic                    st9_tneg_reg;
    logic                    st9_zero_reg;

    logic [33:0]             st9_tmag;

    assign st9_tmag = st8_t_reg[34] ? 34'(-st8_t_reg) : 34'(st8_t_reg);

    // ------------------------------------------------------------------
    // Stage 10: p_i = v_i - rounded(t * u_i)
    // ------------------------------------------------------------------
    logic                    st10_valid_reg;
    logic signed [34:0]      st10_p_reg   [LANES];
    logic signed [32:0]      st10_v_reg   [LANES];
    logic                    st10_tneg_reg;
    logic                    st10_zero_reg;

    logic signed [34:0]      st10_p_next  [LANES];

    always_comb begin
        logic [65:0]        rsum;
        logic [35:0]        r;
        logic signed [36:0] sr;
        logic signed [36:0] diff;
        for (int i = 0; i < LANES; i++) begin
            rsum = {1'b0, st9_prod_reg[i]} + (66'd1 << (UNIT_BITS - 1));
            r    = rsum[65:UNIT_BITS];
            sr   = st9_neg_reg[i] ? -$signed({1'b0, r}) : $signed({1'b0, r});
            diff = 37'(st9_v_reg[i]) - sr;
            st10_p_next[i] = diff[34:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 11: squares of v and p
    // ------------------------------------------------------------------
    logic                    st11_valid_reg;
    logic [63:0]             st11_vsq_reg [LANES];
    logic [67:0]             st11_psq_reg [LANES];
    logic                    st11_tneg_reg;
    logic                    st11_zero_reg;

    logic [31:0]             st11_vmag    [LANES];
    logic [33:0]             st11_pmag    [LANES];

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            st11_vmag[i] = st10_v_reg[i][32] ? 32'(-st10_v_reg[i]) : 32'(st10_v_reg[i]);
            st11_pmag[i] = st10_p_reg[i][34] ? 34'(-st10_p_reg[i]) : 34'(st10_p_reg[i]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 12: sums of squares into the two length square roots
    // ------------------------------------------------------------------
    logic                    st12_valid_reg;
    logic [69:0]             st12_vsum_reg;
    logic [69:0]             st12_psum_reg;
    logic                    st12_tneg_reg;
    logic                    st12_zero_reg;

    logic                    sqv_valid;
    logic                    sqp_valid;
    logic [34:0]             sqv_root;
    logic [34:0]             sqp_root;
    logic                    sqv_zero;
    logic                    sqp_tneg;

    prr_isqrt #(
        .IN_W   (70),
        .PASS_W (1)
    ) u_sqrt_v (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (st12_valid_reg),
        .radicand  (st12_vsum_reg),
        .pass_in   (st12_zero_reg),
        .out_valid (sqv_valid),
        .root      (sqv_root),
        .pass_out  (sqv_zero)
    );

    prr_isqrt #(
        .IN_W   (70),
        .PASS_W (1)
    ) u_sqrt_p (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (st12_valid_reg),
        .radicand  (st12_psum_reg),
        .pass_in   (st12_tneg_reg),
        .out_valid (sqp_valid),
        .root      (sqp_root),
        .pass_out  (sqp_tneg)
    );

    // ------------------------------------------------------------------
    // Stage 13: penalised distance and limit residual
    // ------------------------------------------------------------------
    logic                    st13_valid_reg;
    logic signed [36:0]      st13_dist_reg;
    logic signed [36:0]      st13_resid_reg;
    logic                    st13_zero_reg;

    logic signed [36:0]      st13_dist_next;
    logic signed [36:0]      st13_resid_next;

    always_comb begin
        logic signed [36:0] vn;
        logic signed [36:0] pn;
        logic signed [36:0] under;
        logic signed [36:0] over;
        vn    = $signed({2'b00, sqv_root});
        pn    = $signed({2'b00, sqp_root});
        under = $signed({6'd0, min_dist_reg}) - vn;
        over  = vn - $signed({6'd0, max_dist_reg});
        // target behind the origin: twice |v| less the perpendicular
        st13_dist_next = sqp_tneg ? (vn <<< 1) - pn : pn;
        case (lim_mode_reg)
            2'b01:   st13_resid_next = under;
            2'b10:   st13_resid_next = over;
            2'b11:   st13_resid_next = (over > under) ? over : under;
            default: st13_resid_next = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register: saturate, judge tolerances
    // ------------------------------------------------------------------
    logic [POS_W-1:0]        out_dist_reg;
    logic [31:0]             out_resid_reg;
    logic                    out_active_reg;
    logic                    out_sat_reg;
    logic                    out_zero_reg;

    logic [POS_W-1:0]        out_dist_next;
    logic [31:0]             out_resid_next;
    logic                    out_sat_next;

    always_comb begin
        if (st13_dist_reg < 0) begin
            out_dist_next = '0;
        end else if (st13_dist_reg > 37'sh7FFFFFFF) begin
            out_dist_next = '1;
        end else begin
            out_dist_next = st13_dist_reg[POS_W-1:0];
        end

        if (st13_resid_reg < -37'sh80000000) begin
            out_resid_next = 32'h8000_0000;
        end else if (st13_resid_reg > 37'sh7FFFFFFF) begin
            out_resid_next = 32'h7FFF_FFFF;
        end else begin
            out_resid_next = st13_resid_reg[31:0];
        end

        out_sat_next = (st13_dist_reg <= $signed({6'd0, ray_tol_reg}));
        if ((lim_mode_reg != 2'b00) && (st13_resid_reg > $signed({6'd0, lim_tol_reg}))) begin
            out_sat_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Valid chain: advance together, clear on reset
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg  <= 1'b0;
            st2_valid_reg  <= 1'b0;
            st3_valid_reg  <= 1'b0;
            st4_valid_reg  <= 1'b0;
            st5_valid_reg  <= 1'b0;
            st6_valid_reg  <= 1'b0;
            st7_valid_reg  <= 1'b0;
            st8_valid_reg  <= 1'b0;
            st9_valid_reg  <= 1'b0;
            st10_valid_reg <= 1'b0;
            st11_valid_reg <= 1'b0;
            st12_valid_reg <= 1'b0;
            st13_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else if (ce) begin
            st1_valid_reg  <= s_tvalid;
            st2_valid_reg  <= st1_valid_reg;
            st3_valid_reg  <= st2_valid_reg;
            st4_valid_reg  <= st3_valid_reg;
            st5_valid_reg  <= sqn_valid;
            st6_valid_reg  <= div_valid;
            st7_valid_reg  <= st6_valid_reg;
            st8_valid_reg  <= st7_valid_reg;
            st9_valid_reg  <= st8_valid_reg;
            st10_valid_reg <= st9_valid_reg;
            st11_valid_reg <= st10_valid_reg;
            st12_valid_reg <= st11_valid_reg;
            st13_valid_reg <= sqv_valid && sqp_valid;
            out_valid_reg  <= st13_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Payload: hold on stall, no reset
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < LANES; i++) begin
                st1_v_reg[i]    <= st1_v_next[i];
                st1_md_reg[i]   <= st1_md_next[i];

                st2_v_reg[i]    <= st1_v_reg[i];
                st2_m_reg[i]    <= st1_md_reg[i] << st2_sh;

                st3_v_reg[i]    <= st2_v_reg[i];
                st3_m_reg[i]    <= st2_m_reg[i];
                st3_sq_reg[i]   <= st2_m_reg[i] * st2_m_reg[i];

                st4_v_reg[i]    <= st3_v_reg[i];
                st4_m_reg[i]    <= st3_m_reg[i];

                st5_num_reg[i]  <= {sqn_m[i], UNIT_BITS'(0)} + NUM_W'(sqn_root >> 1);
                st5_v_reg[i]    <= sqn_v[i];

                st6_prod_reg[i] <= st6_vmag[i] * st6_q_next[i];
                st6_neg_reg[i]  <= div_v[i][32] ^ div_dneg[i];
                st6_q_reg[i]    <= st6_q_next[i];
                st6_v_reg[i]    <= div_v[i];

                st7_tv_reg[i]   <= st7_tv_next[i];
                st7_q_reg[i]    <= st6_q_reg[i];
                st7_v_reg[i]    <= st6_v_reg[i];

                st8_q_reg[i]    <= st7_q_reg[i];
                st8_v_reg[i]    <= st7_v_reg[i];

                st9_prod_reg[i] <= st9_tmag * st8_q_reg[i];
                st9_neg_reg[i]  <= st8_t_reg[34] ^ st8_dneg_reg[i];
                st9_v_reg[i]    <= st8_v_reg[i];

                st10_p_reg[i]   <= st10_p_next[i];
                st10_v_reg[i]   <= st9_v_reg[i];

                st11_vsq_reg[i] <= st11_vmag[i] * st11_vmag[i];
                st11_psq_reg[i] <= st11_pmag[i] * st11_pmag[i];
            end

            st1_dneg_reg   <= st1_dneg_next;
            st1_zero_reg   <= (st1_md_next[0] == '0) && (st1_md_next[1] == '0)
                              && (st1_md_next[2] == '0);

            st2_dneg_reg   <= st1_dneg_reg;
            st2_zero_reg   <= st1_zero_reg;
            st3_dneg_reg   <= st2_dneg_reg;
            st3_zero_reg   <= st2_zero_reg;

            st4_sum_reg    <= st3_sq_reg[0] + st3_sq_reg[1] + st3_sq_reg[2];
            st4_dneg_reg   <= st3_dneg_reg;
            st4_zero_reg   <= st3_zero_reg;

            st5_den_reg    <= sqn_root;
            st5_dneg_reg   <= sqn_dneg;
            st5_zero_reg   <= sqn_zero;

            st6_dneg_reg   <= div_dneg;
            st6_zero_reg   <= div_zero;
            st7_dneg_reg   <= st6_dneg_reg;
            st7_zero_reg   <= st6_zero_reg;

            st8_t_reg      <= st8_t_wide[34:0];
            st8_dneg_reg   <= st7_dneg_reg;
            st8_zero_reg   <= st7_zero_reg;

            st9_tneg_reg   <= st8_t_reg[34];
            st9_zero_reg   <= st8_zero_reg;
            st10_tneg_reg  <= st9_tneg_reg;
            st10_zero_reg  <= st9_zero_reg;
            st11_tneg_reg  <= st10_tneg_reg;
            st11_zero_reg  <= st10_zero_reg;

            st12_vsum_reg  <= 70'(st11_vsq_reg[0]) + 70'(st11_vsq_reg[1])
                              + 70'(st11_vsq_reg[2]);
            st12_psum_reg  <= 70'(st11_psq_reg[0]) + 70'(st11_psq_reg[1])
                              + 70'(st11_psq_reg[2]);
            st12_tneg_reg  <= st11_tneg_reg;
            st12_zero_reg  <= st11_zero_reg;

            st13_dist_reg  <= st13_dist_next;
            st13_resid_reg <= st13_resid_next;
            st13_zero_reg  <= sqv_zero;

            out_dist_reg   <= out_dist_next;
            out_resid_reg  <= out_resid_next;
            out_active_reg <= (lim_mode_reg != 2'b00);
            out_sat_reg    <= out_sat_next;
            out_zero_reg   <= st13_zero_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_resid_reg, out_dist_reg};
    assign m_tuser  = {out_zero_reg, out_sat_reg, out_active_reg};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // no limit enabled: residual must read zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_active_reg |-> out_resid_reg == '0)
        else $error("residual non-zero with limits off");

    // limit flag follows the mode register
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_active_reg == (lim_mode_reg != 2'b00))
        else $error("limit_active disagrees with limit mode");

    // satisfied with limits off means the distance is within tolerance
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_active_reg && out_sat_reg |-> out_dist_reg <= ray_tol_reg)
        else $error("satisfied with ray distance over tolerance");

endmodule

FILE: tb/point_at_ray_residual_checker.sv
// ----------------------------------------------------------------------------
// point_at_ray_residual_checker: result predictor and comparator
// Mirrors the register file from the configuration port, computes the
// expected ray distance, limit residual and flags for every accepted input
// word and compares each accepted result word with the oldest expectation.
// ----------------------------------------------------------------------------
module point_at_ray_residual_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [191:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    input  logic [2:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import prr_pkg::*;

    typedef struct packed {
        logic [30:0] ray_distance;
        logic [31:0] limit_residual;
        logic        limit_active;
        logic        satisfied;
        logic        direction_zero;
    } residual_t;

    logic signed [31:0] tgt [LANES];
    logic [30:0] ray_tol, lim_tol, min_d, max_d;
    logic [1:0]  lmode;
    residual_t   expected_q [$];

    function automatic logic [63:0] isqrt(logic [127:0] x);
        logic [63:0] r, c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= x) r = c;
        end
        return r;
    endfunction

    // round(a*u / 2^30), ties away from zero
    function automatic longint round_unit(longint a, longint u);
        logic [127:0] m;
        logic [127:0] r;
        m = (a < 0 ? -a : a) * (u < 0 ? -u : u);
        r = (m + (128'd1 << 29)) >> 30;
        return ((a < 0) != (u < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [63:0] length3(longint c0, longint c1, longint c2);
        logic [127:0] s;
        longint a0, a1, a2;
        a0 = c0 < 0 ? -c0 : c0;
        a1 = c1 < 0 ? -c1 : c1;
        a2 = c2 < 0 ? -c2 : c2;
        s = 128'(a0) * 128'(a0) + 128'(a1) * 128'(a1) + 128'(a2) * 128'(a2);
        return isqrt(s);
    endfunction

    function automatic residual_t predict_residual(logic [191:0] w);
        longint v [3], d [3], u [3], p [3];
        logic [63:0] m [3];
        logic [63:0] mx, n, q, vn, pn;
        longint t, ray_d, resid, over;
        logic zero, sat;
        residual_t r;
        t = 0;
        resid = 0;
        for (int i = 0; i < 3; i++) begin
            v[i] = longint'(tgt[i]) - longint'($signed(w[32*i +: 32]));
            d[i] = longint'($signed(w[96 + 32*i +: 32]));
            m[i] = d[i] < 0 ? -d[i] : d[i];
            u[i] = 0;
        end
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        zero = (mx == 0);
        if (!zero) begin
            while (mx < (64'd1 << 30)) begin
                mx = mx << 1;
                for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            end
            n = isqrt(128'(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]));
            for (int i = 0; i < 3; i++) begin
                q = ((m[i] << 30) + (n >> 1)) / n;
                u[i] = d[i] < 0 ? -longint'(q) : longint'(q);
            end
        end
        for (int i = 0; i < 3; i++) t += round_unit(v[i], u[i]);
        for (int i = 0; i < 3; i++) p[i] = v[i] - round_unit(t, u[i]);
        vn = length3(v[0], v[1], v[2]);
        pn = length3(p[0], p[1], p[2]);
        ray_d = (t < 0) ? 2 * longint'(vn) - longint'(pn) : longint'(pn);
        sat = ray_d <= longint'(ray_tol);
        if (lmode != 0) begin
            if (lmode[0]) resid = longint'(min_d) - longint'(vn);
            if (lmode[1]) begin
                over = longint'(vn) - longint'(max_d);
                if (!lmode[0] || over > resid) resid = over;
            end
            if (resid > longint'(lim_tol)) sat = 1'b0;
        end
        r.ray_distance   = ray_d < 0 ? '0 :
                           (ray_d > 64'h7FFFFFFF ? 31'h7FFFFFFF : ray_d[30:0]);
        r.limit_residual = resid < -64'sh80000000 ? 32'h80000000 :
                           (resid > 64'sh7FFFFFFF ? 32'h7FFFFFFF : resid[31:0]);
        r.limit_active   = lmode != 0;
        r.satisfied      = sat;
        r.direction_zero = zero;
        return r;
    endfunction

    always @(posedge aclk) begin
        residual_t exp_r, got;
        if (!aresetn) begin
            foreach (tgt[i]) tgt[i] <= '0;
            ray_tol <= RAY_TOL_RESET;
            lim_tol <= LIMIT_TOL_RESET;
            min_d   <= '0;
            max_d   <= '0;
            lmode   <= '0;
            fail_count <= 0;
            pending    <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (cfg_reg_t'(paddr[4:2]))
                    REG_TARGET_X:   tgt[0]  <= pwdata;
                    REG_TARGET_Y:   tgt[1]  <= pwdata;
                    REG_TARGET_Z:   tgt[2]  <= pwdata;
                    REG_RAY_TOL:    ray_tol <= pwdata[30:0];
                    REG_LIMIT_TOL:  lim_tol <= pwdata[30:0];
                    REG_MIN_DIST:   min_d   <= pwdata[30:0];
                    REG_MAX_DIST:   max_d   <= pwdata[30:0];
                    REG_LIMIT_MODE: lmode   <= pwdata[1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_q.insert(expected_q.size(), predict_residual(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[30:0], m_tdata[62:31], m_tuser[0], m_tuser[1], m_tuser[2]};
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got != exp_r) begin
                        $display("%0t: dist exp %h got %h, resid exp %h got %h, flags exp %b got %b",
                                 $time, exp_r.ray_distance, got.ray_distance,
                                 exp_r.limit_residual, got.limit_residual,
                                 {exp_r.limit_active, exp_r.satisfied, exp_r.direction_zero},
                                 {got.limit_active, got.satisfied, got.direction_zero});
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

FILE: tb/point_at_ray_residual_top_tb.sv
// ----------------------------------------------------------------------------
// point_at_ray_residual_top_tb: stimulus and verdict for the ray residual
// Programs several register settings, sends directed and random ray words
// with random gaps on both sides and lets the checker judge every result.
// ----------------------------------------------------------------------------
module point_at_ray_residual_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import prr_pkg::*;

    localparam int LATENCY = 112;

    logic         aclk, aresetn;
    logic         s_tvalid, s_tready;
    logic [191:0] s_tdata;      // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    logic         m_tvalid, m_tready;
    logic [63:0]  m_tdata;      // ray_distance, limit_residual, pad
    logic [2:0]   m_tuser;      // limit_active, satisfied, direction_zero
    logic         psel, penable, pwrite, pready;
    logic [4:0]   paddr;
    logic [31:0]  pwdata, prdata;
    int           fail_count, pending;
    logic         calm;         // suppress idling on both sides
    logic         hold_sink;    // long stall of the result side

    point_at_ray_residual_top dut (.*);

    point_at_ray_residual_checker u_checker (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
        .m_tdata, .m_tuser, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .fail_count, .pending
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Generous cap: ~1100 words, each with worst-case gaps, plus drains.
    initial begin
        #4ms;
        $display("Mismatches found");
        $finish;
    end

    // Result side: random stalls, none while calm, long hold when asked.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            m_tready <= !hold_sink && (calm || $urandom_range(99) >= 21);
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Offer one word and hold it until taken; random gaps go before it,
    // with no gap the next word follows straight on.
    task automatic send_ray(logic [191:0] w);
        while (!calm && $urandom_range(99) < 21) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop the input, wait for every expected word, then let the pipeline empty.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'h80000000;
            2: return 32'h7FFFFFFF;
            default: return 32'($signed($urandom_range(20 << 16)) - (10 << 16));
        endcase
    endfunction

    function automatic logic [191:0] rand_ray();
        logic [191:0] w;
        for (int i = 0; i < 6; i++) w[32*i +: 32] = rand_coord();
        if ($urandom_range(19) == 0) w[191:96] = '0;
        return w;
    endfunction

    task automatic load_setting(logic [31:0] tx, ty, tz, rtol, ltol, mn, mx, mode);
        write_reg(REG_TARGET_X, tx);
        write_reg(REG_TARGET_Y, ty);
        write_reg(REG_TARGET_Z, tz);
        write_reg(REG_RAY_TOL, rtol);
        write_reg(REG_LIMIT_TOL, ltol);
        write_reg(REG_MIN_DIST, mn);
        write_reg(REG_MAX_DIST, mx);
        write_reg(REG_LIMIT_MODE, mode);
    endtask

    initial begin
        logic [31:0] ext [4] = '{32'h80000000, 32'h7FFFFFFF, 32'h0, 32'hFFFFFFFF};
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        calm = 1'b0; hold_sink = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset setting, extremes, zero direction, target behind.
        send_ray('0);
        send_ray({96'd0, 32'd0, 32'd0, 32'h00010000});
        send_ray({32'd0, 32'd0, 32'h00010000, 32'd0, 32'd0, 32'h00050000});
        send_ray({32'd0, 32'd0, 32'hFFFF0000, 32'd0, 32'd0, 32'h00050000});
        foreach (ext[i]) foreach (ext[j]) send_ray({{3{ext[j]}}, {3{ext[i]}}});
        send_ray({32'd1, 32'd0, 32'd0, 96'd0});
        drain();

        // Both limits, minimum above maximum, extreme target.
        load_setting(32'h7FFFFFFF, 32'h80000000, 32'h00030000, 32'h7FFFFFFF,
                     32'h0, 32'h7FFFFFFF, 32'h0, 32'd3);
        for (int i = 0; i < 6; i++) send_ray(rand_ray());
        drain();

        // Sweep the limit modes with random settings; one mode per phase.
        for (int phase = 0; phase < 8; phase++) begin
            load_setting($urandom_range(8 << 16), 32'($signed($urandom_range(8 << 16)) - (4 << 16)),
                         $urandom, $urandom_range(phase < 4 ? 32'h7FFFFFFF : (4 << 16)),
                         $urandom_range(2 << 16), $urandom_range(16 << 16),
                         $urandom_range(32 << 16), phase % 4);
            calm <= (phase == 2);
            // Long output hold while input keeps offering: pipeline fills up.
            if (phase == 5) begin
                hold_sink <= 1'b1;
                fork
                    begin
                        repeat (400) @(posedge aclk);
                        hold_sink <= 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < 125; k++) begin
                send_ray(rand_ray());
                // Sender pause until all results are back.
                if (phase == 6 && k == 60) begin
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                    while (pending != 0) @(posedge aclk);
                end
            end
            drain();
        end
        calm <= 1'b0;
        // Back to reset values.
        load_setting(0, 0, 0, 655, 66, 0, 0, 0);
        for (int i = 0; i < 20; i++) send_ray(rand_ray());
        drain();

        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
